FILE: hw/rtl/prh_pkg.sv
// ----------------------------------------------------------------------------
// prh_pkg: shared definitions for the polygon region hit test
// Table geometry, field widths, configuration codes and the records that
// pass between the edge former and the edge evaluator.
// ----------------------------------------------------------------------------
package prh_pkg;

  // Table geometry and ray end.
  localparam int MAX_REGIONS  = 8;
  localparam int MAX_VERTICES = 4;
  localparam int RAY_END_X    = 10000;

  localparam int REG_W   = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int VTX_W   = $clog2(MAX_VERTICES);
  localparam int NREG_W  = $clog2(MAX_REGIONS + 1);
  localparam int NVTX_W  = $clog2(MAX_VERTICES + 1);
  localparam int DEPTH   = MAX_REGIONS * MAX_VERTICES;
  localparam int ADDR_W  = $clog2(DEPTH);

  // Item fields.
  localparam int C_W        = 13;
  localparam int ENTRY_W    = 2 * C_W;
  localparam int RSEL_W     = 3;
  localparam int VSEL_W     = 2;
  localparam int S_DATA_W   = 32;
  localparam int M_DATA_W   = 8;
  localparam int OUT_REG_W  = 3;

  // Arithmetic widths: coordinates and the ray end share F_W bits, a
  // difference needs one more, a product twice that, a cross term one more.
  localparam int F_W = 14;
  localparam int D_W = F_W + 1;
  localparam int P_W = 2 * D_W;
  localparam int V_W = P_W + 1;

  // Far end of the query ray at arithmetic width.
  localparam logic [F_W-1:0] FAR_X = F_W'(RAY_END_X);

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int RCNT_W     = 4;
  localparam int VCNT_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = CFG_IDX_W'(1);
  localparam logic [RCNT_W-1:0]    RCNT_RESET       = RCNT_W'(7);
  localparam logic [VCNT_W-1:0]    VCNT_RESET       = VCNT_W'(4);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    TURN_COL = 2'd0,
    TURN_CW  = 2'd1,
    TURN_CCW = 2'd2
  } turn_t;

  // One polygon edge from a to b, tagged with its region.
  typedef struct packed {
    logic             valid;
    logic             close;     // closing edge, the region ends here
    logic             last_rgn;  // region is the last one of the query
    logic [REG_W-1:0] reg_idx;
    logic [C_W-1:0]   ax;
    logic [C_W-1:0]   ay;
    logic [C_W-1:0]   bx;
    logic [C_W-1:0]   by;
  } edge_t;

  // Outcome of one region.
  typedef struct packed {
    logic             valid;
    logic             holds;
    logic             last_rgn;
    logic [REG_W-1:0] reg_idx;
  } verdict_t;

  function automatic logic [ADDR_W-1:0] vtx_addr(input int r, input int v);
    return ADDR_W'(r * MAX_VERTICES + v);
  endfunction

endpackage

FILE: hw/rtl/prh_ram.sv
// ----------------------------------------------------------------------------
// prh_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module prh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/prh_edge_eval.sv
// ----------------------------------------------------------------------------
// prh_edge_eval: edge crossing test and per-region crossing count
// Two stages: the cross products and bounding boxes of one edge against the
// query ray, then the orientation decisions and the running parity.
// ----------------------------------------------------------------------------
module prh_edge_eval (
  input  logic                    clk,
  input  logic                    rst,
  input  prh_pkg::edge_t          edge_in,
  input  logic [prh_pkg::C_W-1:0] px,
  input  logic [prh_pkg::C_W-1:0] py,
  output prh_pkg::verdict_t       verdict
);

  import prh_pkg::*;

  function automatic logic signed [D_W-1:0] sub(input logic [F_W-1:0] a,
                                                input logic [F_W-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic turn_t turn_of(input logic signed [V_W-1:0] v);
    turn_t t;
    if (v == '0) begin
      t = TURN_COL;
    end else if (v > 0) begin
      t = TURN_CW;
    end else begin
      t = TURN_CCW;
    end
    return t;
  endfunction

  // Stage one: products and boxes.
  logic [F_W-1:0] ax, ay, bx, by, pxf, pyf;
  logic [F_W-1:0] xmax, xmin, ymax, ymin;
  logic signed [D_W-1:0] dy_ab, dx_ab;

  logic signed [P_W-1:0] m1a, m1b, m2a, m3, m4, m5a, m5b;
  logic box2, box3, box4, box5;
  logic mv, mclose, mlast;
  logic [REG_W-1:0] mreg;

  assign ax  = {1'b0, edge_in.ax};
  assign ay  = {1'b0, edge_in.ay};
  assign bx  = {1'b0, edge_in.bx};
  assign by  = {1'b0, edge_in.by};
  assign pxf = {1'b0, px};
  assign pyf = {1'b0, py};

  assign xmax  = (ax > bx) ? ax : bx;
  assign xmin  = (ax > bx) ? bx : ax;
  assign ymax  = (ay > by) ? ay : by;
  assign ymin  = (ay > by) ? by : ay;
  assign dy_ab = sub(by, ay);
  assign dx_ab = sub(bx, ax);

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else begin
      mv <= edge_in.valid;
    end
    mclose <= edge_in.close;
    mlast  <= edge_in.last_rgn;
    mreg   <= edge_in.reg_idx;
    // turn(a, b, p) and turn(a, b, far) share the second term.
    m1a <= P_W'(dy_ab) * P_W'(sub(pxf, bx));
    m1b <= P_W'(dx_ab) * P_W'(sub(pyf, by));
    m2a <= P_W'(dy_ab) * P_W'(sub(FAR_X, bx));
    // turn(p, far, a) and turn(p, far, b), kept without their minus sign.
    m3  <= P_W'(sub(FAR_X, pxf)) * P_W'(sub(ay, pyf));
    m4  <= P_W'(sub(FAR_X, pxf)) * P_W'(sub(by, pyf));
    // turn(a, p, b).
    m5a <= P_W'(sub(pyf, ay)) * P_W'(sub(bx, pxf));
    m5b <= P_W'(sub(pxf, ax)) * P_W'(sub(by, pyf));
    box5 <= (pxf <= xmax) && (pxf >= xmin) && (pyf <= ymax) && (pyf >= ymin);
    box2 <= (FAR_X <= xmax) && (FAR_X >= xmin) && (pyf <= ymax) && (pyf >= ymin);
    box3 <= (ax <= FAR_X) && (ax >= pxf) && (ay == pyf);
    box4 <= (bx <= FAR_X) && (bx >= pxf) && (by == pyf);
  end

  // Stage two: orientation decisions and the region accumulator.
  turn_t t1, t2, t3, t4, t5;
  logic  meet;
  logic  par, done, val;
  logic  par_next, done_next, val_next;

  assign t1 = turn_of(V_W'(m1a) - V_W'(m1b));
  assign t2 = turn_of(V_W'(m2a) - V_W'(m1b));
  assign t3 = turn_of(-V_W'(m3));
  assign t4 = turn_of(-V_W'(m4));
  assign t5 = turn_of(V_W'(m5a) - V_W'(m5b));

  assign meet = ((t1 != t2) && (t3 != t4)) ||
                ((t1 == TURN_COL) && box5) || ((t2 == TURN_COL) && box2) ||
                ((t3 == TURN_COL) && box3) || ((t4 == TURN_COL) && box4);

  // A crossed edge that is collinear with the point settles the region.
  always_comb begin
    par_next  = par;
    done_next = done;
    val_next  = val;
    if (!done && meet) begin
      if (t5 == TURN_COL) begin
        done_next = 1'b1;
        val_next  = box5;
      end else begin
        par_next = ~par;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      par           <= 1'b0;
      done          <= 1'b0;
      val           <= 1'b0;
      verdict.valid <= 1'b0;
    end else begin
      verdict.valid <= mv && mclose;
      if (mv) begin
        if (mclose) begin
          par  <= 1'b0;
          done <= 1'b0;
          val  <= 1'b0;
        end else begin
          par  <= par_next;
          done <= done_next;
          val  <= val_next;
        end
      end
    end
    verdict.holds    <= done_next ? val_next : par_next;
    verdict.last_rgn <= mlast;
    verdict.reg_idx  <= mreg;
  end

endmodule

FILE: hw/rtl/polygon_region_hit_test.sv
// ----------------------------------------------------------------------------
// polygon_region_hit_test: first polygon region that holds a point
// Vertex table in a RAM, ray casting query walked one edge per cycle.
// ----------------------------------------------------------------------------
// A write word (op = 0) stores one vertex of one region.
// A query word (op = 1) tests regions 0 .. region_count-1 in order, casting a
// horizontal ray from the point to x = 10000, and returns one result word:
// hit and the first region that holds the point (region 0 without a hit).
// A point on an edge counts as inside. Each query reads the vertex RAM once
// per vertex, one read a cycle through its single read port, and evaluates
// one edge a cycle. A query with no region or fewer than three vertices
// reads no vertex and reports no hit. The next word is taken once the query
// has handed its result to the output register, which holds it until the
// sink takes it. Configuration must be written through the cfg channel while
// no query runs; the block itself does not enforce this.
// Vertices that were never written read back as whatever the RAM holds.
module polygon_region_hit_test (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // region_sel[2:0], vertex_sel[4:3], coord_x[17:5], coord_y[30:18], zero[31]
  input  logic [prh_pkg::S_DATA_W-1:0]   s_tdata,
  // op[0]
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // region[2:0], zero[7:3]
  output logic [prh_pkg::M_DATA_W-1:0]   m_tdata,
  // hit[0]
  output logic [0:0]                     m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [prh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prh_pkg::CFG_DATA_W-1:0] cfg_data
);

  import prh_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state;

  // Input word fields.
  logic [RSEL_W-1:0] in_rsel;
  logic [VSEL_W-1:0] in_vsel;
  logic [C_W-1:0]    in_x, in_y;
  logic              in_op;
  logic              in_fire;

  assign in_rsel = s_tdata[RSEL_W-1:0];
  assign in_vsel = s_tdata[RSEL_W+VSEL_W-1:RSEL_W];
  assign in_x    = s_tdata[RSEL_W+VSEL_W+C_W-1:RSEL_W+VSEL_W];
  assign in_y    = s_tdata[RSEL_W+VSEL_W+2*C_W-1:RSEL_W+VSEL_W+C_W];
  assign in_op   = s_tuser[0];
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  // Configuration registers; both counts saturate at the table size.
  logic [RCNT_W-1:0] region_count;
  logic [VCNT_W-1:0] vertex_count;
  logic [NREG_W-1:0] nreg;
  logic [NVTX_W-1:0] nvtx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= RCNT_RESET;
      vertex_count <= VCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REGION_COUNT: region_count <= cfg_data[RCNT_W-1:0];
        CFG_VERTEX_COUNT: vertex_count <= cfg_data[VCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign nreg = (int'(region_count) > MAX_REGIONS) ? NREG_W'(MAX_REGIONS)
                                                   : NREG_W'(region_count);
  assign nvtx = (int'(vertex_count) > MAX_VERTICES) ? NVTX_W'(MAX_VERTICES)
                                                    : NVTX_W'(vertex_count);

  // Vertex RAM: x in the upper half of an entry, y in the lower half.
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_issue;
  logic [ADDR_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  // Writes outside the table are dropped.
  assign wr_en   = in_fire && (in_op == OP_WRITE) &&
                   (int'(in_rsel) < MAX_REGIONS) && (int'(in_vsel) < MAX_VERTICES);
  assign wr_addr = vtx_addr(int'(in_rsel), int'(in_vsel));

  prh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_vertex_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_x, in_y}),
    .rd_en   (rd_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Read sequencer: every vertex of every tested region, in order.
  logic [REG_W-1:0] rd_reg;
  logic [VTX_W-1:0] rd_vtx;
  logic             rd_last_vtx, rd_last_reg;
  logic [C_W-1:0]   px, py;

  assign rd_issue    = (state == ST_RUN);
  assign rd_addr     = vtx_addr(int'(rd_reg), int'(rd_vtx));
  assign rd_last_vtx = (rd_vtx == VTX_W'(nvtx - 1'b1));
  assign rd_last_reg = (rd_reg == REG_W'(nreg - 1'b1));

  // Region results collected as the evaluator hands them over.
  verdict_t         verdict;
  logic             found;
  logic [REG_W-1:0] found_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      found    <= 1'b0;
    end else begin
      // In ST_DONE a new result may take the output register over instead.
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      if (verdict.valid && verdict.holds && !found) begin
        found     <= 1'b1;
        found_reg <= verdict.reg_idx;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire && (in_op == OP_QUERY)) begin
            px     <= in_x;
            py     <= in_y;
            found  <= 1'b0;
            rd_reg <= '0;
            rd_vtx <= '0;
            // With no region or a degenerate polygon nothing can hit.
            if ((nreg == '0) || (nvtx < NVTX_W'(3))) begin
              state <= ST_DONE;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (rd_last_vtx) begin
            rd_vtx <= '0;
            rd_reg <= rd_reg + 1'b1;
            if (rd_last_reg) begin
              state <= ST_DRAIN;
            end
          end else begin
            rd_vtx <= rd_vtx + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (verdict.valid && verdict.last_rgn) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= found;
            m_tdata  <= {{(M_DATA_W-OUT_REG_W){1'b0}},
                         found ? OUT_REG_W'(found_reg) : OUT_REG_W'(0)};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Edge former. Read data arrives in the cycle after its address; each vertex
  // after the first closes an edge with the one before it. The closing edge
  // of a region goes out in the slot of the next region's first vertex,
  // which forms no edge itself, or in the cycle after the final read.
  logic             d_valid, d_first, d_final;
  logic [REG_W-1:0] d_reg;
  logic             close_pend, have_first;
  logic [C_W-1:0]   first_x, first_y, prev_x, prev_y;
  logic [REG_W-1:0] first_reg;
  logic [C_W-1:0]   data_x, data_y;
  edge_t            cur_edge;

  assign data_x = rd_data[ENTRY_W-1:C_W];
  assign data_y = rd_data[C_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid        <= 1'b0;
      close_pend     <= 1'b0;
      have_first     <= 1'b0;
      cur_edge.valid <= 1'b0;
    end else begin
      d_valid        <= rd_issue;
      close_pend     <= d_valid && d_final;
      cur_edge.valid <= d_valid ? (!d_first || have_first) : close_pend;
      if (d_valid) begin
        if (d_first) begin
          have_first <= 1'b1;
        end
      end else if (close_pend) begin
        have_first <= 1'b0;
      end
    end

    d_first <= (rd_vtx == '0);
    d_final <= rd_last_vtx && rd_last_reg;
    d_reg   <= rd_reg;

    if (d_valid) begin
      prev_x <= data_x;
      prev_y <= data_y;
      if (d_first) begin
        first_x   <= data_x;
        first_y   <= data_y;
        first_reg <= d_reg;
      end
    end

    cur_edge.ax <= prev_x;
    cur_edge.ay <= prev_y;
    if (d_valid && !d_first) begin
      cur_edge.close   <= 1'b0;
      cur_edge.reg_idx <= d_reg;
      cur_edge.bx      <= data_x;
      cur_edge.by      <= data_y;
    end else begin
      cur_edge.close   <= 1'b1;
      cur_edge.reg_idx <= first_reg;
      cur_edge.bx      <= first_x;
      cur_edge.by      <= first_y;
    end
    cur_edge.last_rgn <= !d_valid && close_pend;
  end

  prh_edge_eval u_edge_eval (
    .clk     (clk),
    .rst     (rst),
    .edge_in (cur_edge),
    .px      (px),
    .py      (py),
    .verdict (verdict)
  );

endmodule
